// ----- hdl/nsr_pkg.sv -----
// Shared constants and types for the SNTP server responder.
package nsr_pkg;

	localparam int unsigned KIND_W   = 2;
	localparam int unsigned SEC_W    = 32;
	localparam int unsigned MS_W     = 10;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned PKT_BYTES  = 48;
	localparam int unsigned PKT_BITS   = PKT_BYTES * BYTE_W;
	localparam int unsigned STAMP_W    = 64;

	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [SEC_W-1:0]      sec_t;
	typedef logic [MS_W-1:0]       ms_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// item kinds
	localparam kind_t KIND_TICK    = 2'd0;
	localparam kind_t KIND_SET     = 2'd1;
	localparam kind_t KIND_REQUEST = 2'd2;
	localparam kind_t KIND_UNUSED  = 2'd3;

	// register indexes
	localparam cfg_idx_t REG_STRATUM   = 2'd0;
	localparam cfg_idx_t REG_POLL      = 2'd1;
	localparam cfg_idx_t REG_PRECISION = 2'd2;
	localparam cfg_idx_t REG_REF_ID    = 2'd3;

	localparam byte_t RST_STRATUM   = 8'd1;
	localparam byte_t RST_POLL      = 8'd6;
	localparam byte_t RST_PRECISION = 8'hEC;
	localparam logic [31:0] RST_REF_ID = 32'h4C4F4332;

	localparam byte_t MODE_BYTE = 8'h24;
	localparam sec_t  NTP_EPOCH_OFFSET = 32'd2208988800;
	localparam ms_t   MS_MAX = 10'd999;
	localparam cnt_t  CNT_FULL = 6'd48;
	localparam cnt_t  CNT_ORIG = 6'd40;
	localparam cnt_t  CNT_LAST_IDX = 6'd47;

	// 2^32/1000 = 4294967.296: integer part times ms, plus floor(ms*37/125)
	// done as (ms * 1241535) >> 22, exact over 0..999
	localparam logic [31:0] MS_TO_FRAC      = 32'd4294967;
	localparam logic [30:0] FRAC_FINE_MUL   = 31'd1241535;
	localparam int unsigned FRAC_FINE_SHIFT = 22;

endpackage

// ----- hdl/ntp_server_responder.sv -----
// SNTP server responder: clock keeping, request parsing and reply streaming.
// The last request byte passes through the input register and the reply sender before the first reply byte is output.
// Throughput: one item per cycle unless a reply start is held; a reply is 48 bytes, one per cycle while not stalled.
// A packet end that starts a reply while the previous reply is still sending waits
// in the input register until the sender has loaded the last byte of that reply.
// Reset clears the clock, time valid flag, byte count and handshakes; config takes its defaults.
module ntp_server_responder (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  nsr_pkg::kind_t           kind,
	input  logic [31:0]              set_seconds,
	input  logic [9:0]               set_millis,
	input  logic [7:0]               request_byte,
	input  logic                     request_last,
	output logic                     reply_valid,
	input  logic                     reply_stall,
	output logic [7:0]               response_byte,
	output logic                     response_last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  nsr_pkg::cfg_idx_t        cfg_index,
	input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nsr_pkg::*;

	// configuration
	byte_t       stratum_q;
	byte_t       poll_q;
	byte_t       precision_q;
	logic [31:0] ref_id_q;

	// input register
	logic   valid_s1;
	kind_t  kind_s1;
	sec_t   set_sec_s1;
	ms_t    set_ms_s1;
	byte_t  req_byte_s1;
	logic   req_last_s1;

	// clock and parser state
	sec_t   clock_sec_q;
	ms_t    clock_ms_q;
	logic   time_valid_q;
	cnt_t   bytes_seen_q;
	logic [STAMP_W-1:0] orig_q;

	// reply sender
	logic   send_busy_q;
	cnt_t   send_idx_q;
	logic [STAMP_W-1:0] snap_orig_q;
	sec_t   snap_sec_q;
	logic [31:0] snap_frac_q;

	// output register
	logic   out_valid_q;
	byte_t  out_byte_q;
	logic   out_last_q;

	logic   accept;
	logic   start_reply;
	logic   advance;
	cnt_t   seen_next;
	ms_t    set_ms_clamped;
	logic [30:0] frac_fine;
	logic [31:0] frac_c;
	logic   out_load;
	logic [PKT_BITS-1:0] pkt;
	logic [8:0] bit_off;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stratum_q   <= RST_STRATUM;
			poll_q      <= RST_POLL;
			precision_q <= RST_PRECISION;
			ref_id_q    <= RST_REF_ID;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STRATUM:   stratum_q   <= cfg_data[7:0];
				REG_POLL:      poll_q      <= cfg_data[7:0];
				REG_PRECISION: precision_q <= cfg_data[7:0];
				REG_REF_ID:    ref_id_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// packet-end decision from the current count
	always_comb begin
		seen_next = (bytes_seen_q < CNT_FULL) ? bytes_seen_q + 6'd1 : bytes_seen_q;
		start_reply = valid_s1 && (kind_s1 == KIND_REQUEST) && req_last_s1 &&
			(seen_next >= CNT_FULL) && time_valid_q && (clock_sec_q != '0);
		set_ms_clamped = (set_ms_s1 > MS_MAX) ? MS_MAX : set_ms_s1;
	end

	// hold a reply start until the sender is free
	assign advance    = valid_s1 && !(start_reply && send_busy_q);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			set_sec_s1  <= set_seconds;
			set_ms_s1   <= set_millis;
			req_byte_s1 <= request_byte;
			req_last_s1 <= request_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_sec_q  <= '0;
			clock_ms_q   <= '0;
			time_valid_q <= 1'b0;
			bytes_seen_q <= '0;
		end else if (advance) begin
			unique case (kind_s1)
				KIND_TICK: begin
					if (time_valid_q) begin
						if (clock_ms_q >= MS_MAX) begin
							clock_ms_q  <= '0;
							clock_sec_q <= clock_sec_q + 32'd1;
						end else begin
							clock_ms_q <= clock_ms_q + 10'd1;
						end
					end
				end
				KIND_SET: begin
					clock_sec_q  <= set_sec_s1;
					clock_ms_q   <= set_ms_clamped;
					time_valid_q <= (set_sec_s1 != '0);
				end
				KIND_REQUEST: begin
					bytes_seen_q <= req_last_s1 ? '0 : seen_next;
				end
				KIND_UNUSED: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (kind_s1 == KIND_REQUEST) &&
			(bytes_seen_q >= CNT_ORIG) && (bytes_seen_q < CNT_FULL)) begin
			orig_q <= {orig_q[STAMP_W-9:0], req_byte_s1};
		end
	end

	// fraction of a second in 2^-32 units
	always_comb begin
		frac_fine = 31'(clock_ms_q) * FRAC_FINE_MUL;
		frac_c = 32'(clock_ms_q) * MS_TO_FRAC + 32'(frac_fine >> FRAC_FINE_SHIFT);
	end

	// the 48th byte is still on its way into orig_q: take it from the input register
	always_ff @(posedge clk) begin
		if (advance && start_reply) begin
			snap_orig_q <= (bytes_seen_q < CNT_FULL) ?
				{orig_q[STAMP_W-9:0], req_byte_s1} : orig_q;
			snap_sec_q  <= clock_sec_q + NTP_EPOCH_OFFSET;
			snap_frac_q <= frac_c;
		end
	end

	assign out_load = !out_valid_q || !reply_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_busy_q <= 1'b0;
			send_idx_q  <= '0;
		end else if (advance && start_reply) begin
			send_busy_q <= 1'b1;
			send_idx_q  <= '0;
		end else if (send_busy_q && out_load) begin
			send_idx_q <= send_idx_q + 6'd1;
			if (send_idx_q == CNT_LAST_IDX) begin
				send_busy_q <= 1'b0;
			end
		end
	end

	assign pkt = {MODE_BYTE, stratum_q, poll_q, precision_q, 64'd0, ref_id_q, 64'd0,
		snap_orig_q, snap_sec_q, snap_frac_q, snap_sec_q, snap_frac_q};
	assign bit_off = 9'(PKT_BITS - BYTE_W) - {send_idx_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= send_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && send_busy_q) begin
			out_byte_q <= pkt[bit_off +: BYTE_W];
			out_last_q <= (send_idx_q == CNT_LAST_IDX);
		end
	end

	assign reply_valid   = out_valid_q;
	assign response_byte = out_byte_q;
	assign response_last = out_last_q;

endmodule
